// ===== design/tocc_pkg.sv =====
package tocc_pkg;

  // Defaults for the top-level parameters
  localparam int DEF_MAX_OBSTACLES = 16;
  localparam int DEF_COORD_WIDTH   = 16;

  // Fixed result field widths
  localparam int HIT_W   = 4;
  localparam int COUNT_W = 5;

  // Operation codes of the input word
  localparam logic OP_ADD   = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Operand source of the edge evaluators
  typedef enum logic [1:0] {
    SRC_ROW    = 2'd0,  // stored edge row against the query point
    SRC_EDGE_C = 2'd1,  // cross products that form an edge's c term
    SRC_EDGE_O = 2'd2   // new edge against its opposite vertex
  } src_t;

  typedef struct packed {
    logic load;
    logic rd_en;
    logic wr_en;
    logic cap_c;
    logic flush;
    src_t src;
  } cmd_t;

  typedef struct packed {
    logic chk_valid;
    logic chk_hit;
  } sts_t;

endpackage

// ===== design/tocc_edge_eval.sv =====
module tocc_edge_eval import tocc_pkg::*; #(
  parameter int COORD_WIDTH = DEF_COORD_WIDTH
) (
  input  logic                            clk,
  input  logic signed [COORD_WIDTH:0]     a_i,
  input  logic signed [COORD_WIDTH:0]     b_i,
  input  logic signed [2*COORD_WIDTH+2:0] c_i,
  input  logic signed [COORD_WIDTH-1:0]   x_i,
  input  logic signed [COORD_WIDTH-1:0]   y_i,
  output logic signed [2*COORD_WIDTH+2:0] sum_o
);

  localparam int AW = COORD_WIDTH + 1;
  localparam int PW = AW + COORD_WIDTH;
  localparam int SW = PW + 2;

  logic signed [PW-1:0] pa_r;
  logic signed [PW-1:0] pb_r;
  logic signed [SW-1:0] cd_r;
  logic signed [SW-1:0] sum_r;

  // a*x + b*y + c over two stages, exact
  always_ff @(posedge clk) begin
    pa_r  <= PW'(a_i) * PW'(x_i);
    pb_r  <= PW'(b_i) * PW'(y_i);
    cd_r  <= c_i;
    sum_r <= SW'(pa_r) + SW'(pb_r) + cd_r;
  end

  assign sum_o = sum_r;

endmodule

// ===== design/tocc_dp.sv =====
module tocc_dp import tocc_pkg::*; #(
  parameter int MAX_OBSTACLES = DEF_MAX_OBSTACLES,
  parameter int COORD_WIDTH   = DEF_COORD_WIDTH
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  cmd_t                                 cmd,
  input  logic [$clog2(MAX_OBSTACLES)-1:0]     addr,
  input  logic signed [COORD_WIDTH-1:0]        ax,
  input  logic signed [COORD_WIDTH-1:0]        ay,
  input  logic signed [COORD_WIDTH-1:0]        bx,
  input  logic signed [COORD_WIDTH-1:0]        by,
  input  logic signed [COORD_WIDTH-1:0]        cx,
  input  logic signed [COORD_WIDTH-1:0]        cy,
  input  logic signed [COORD_WIDTH-1:0]        px,
  input  logic signed [COORD_WIDTH-1:0]        py,
  output sts_t                                 sts,
  output logic [$clog2(MAX_OBSTACLES)-1:0]     chk_idx
);

  localparam int IDXW = $clog2(MAX_OBSTACLES);
  localparam int AW   = COORD_WIDTH + 1;
  localparam int CCW  = 2 * COORD_WIDTH + 1;
  localparam int SW   = 2 * COORD_WIDTH + 3;
  localparam int EW   = 2 * AW + CCW;
  localparam int RW   = 3 * EW;

  logic signed [COORD_WIDTH-1:0] vx_r [3];
  logic signed [COORD_WIDTH-1:0] vy_r [3];
  logic signed [COORD_WIDTH-1:0] px_r;
  logic signed [COORD_WIDTH-1:0] py_r;

  logic [RW-1:0] mem [MAX_OBSTACLES];
  logic [RW-1:0] row_r;
  logic [RW-1:0] wr_row;

  logic signed [CCW-1:0] c_r [3];
  logic signed [SW-1:0]  sum [3];
  logic [2:0]            pos;

  logic            rd_v_r, s1_v_r, s2_v_r;
  logic [IDXW-1:0] rd_idx_r, s1_idx_r, s2_idx_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      vx_r[0] <= ax;
      vy_r[0] <= ay;
      vx_r[1] <= bx;
      vy_r[1] <= by;
      vx_r[2] <= cx;
      vy_r[2] <= cy;
      px_r    <= px;
      py_r    <= py;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      row_r <= mem[addr];
    end
    if (cmd.wr_en) begin
      mem[addr] <= wr_row;
    end
  end

  // Lane l holds edge from vertex l to vertex l+1, checked against vertex l+2
  for (genvar l = 0; l < 3; l++) begin : g_lane
    localparam int LQ = (l + 1) % 3;
    localparam int LO = (l + 2) % 3;

    logic signed [AW-1:0]          ea, eb, ra, rb, op_a, op_b, wa, wb;
    logic signed [CCW-1:0]         rc, wc;
    logic signed [SW-1:0]          op_c;
    logic signed [COORD_WIDTH-1:0] op_x, op_y;

    assign ea = AW'(vy_r[l]) - AW'(vy_r[LQ]);
    assign eb = AW'(vx_r[LQ]) - AW'(vx_r[l]);
    assign rc = $signed(row_r[l*EW +: CCW]);
    assign rb = $signed(row_r[l*EW + CCW +: AW]);
    assign ra = $signed(row_r[l*EW + CCW + AW +: AW]);

    always_comb begin
      unique case (cmd.src)
        SRC_ROW: begin
          op_a = ra;
          op_b = rb;
          op_c = SW'(rc);
          op_x = px_r;
          op_y = py_r;
        end
        SRC_EDGE_C: begin
          op_a = AW'(vy_r[LQ]);
          op_b = -AW'(vy_r[l]);
          op_c = '0;
          op_x = vx_r[l];
          op_y = vx_r[LQ];
        end
        SRC_EDGE_O: begin
          op_a = ea;
          op_b = eb;
          op_c = sum[l];
          op_x = vx_r[LO];
          op_y = vy_r[LO];
        end
        default: begin
          op_a = '0;
          op_b = '0;
          op_c = '0;
          op_x = '0;
          op_y = '0;
        end
      endcase
    end

    tocc_edge_eval #(
      .COORD_WIDTH(COORD_WIDTH)
    ) u_eval (
      .clk   (clk),
      .a_i   (op_a),
      .b_i   (op_b),
      .c_i   (op_c),
      .x_i   (op_x),
      .y_i   (op_y),
      .sum_o (sum[l])
    );

    assign pos[l] = !sum[l][SW-1] && (sum[l] != '0);

    always_ff @(posedge clk) begin
      if (cmd.cap_c) begin
        c_r[l] <= sum[l][CCW-1:0];
      end
    end

    // Flip the edge when the opposite vertex is not strictly positive
    assign wa = pos[l] ? ea : -ea;
    assign wb = pos[l] ? eb : -eb;
    assign wc = pos[l] ? c_r[l] : -c_r[l];
    assign wr_row[l*EW +: EW] = {wa, wb, wc};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_v_r <= 1'b0;
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      rd_v_r <= cmd.rd_en && !cmd.flush;
      s1_v_r <= rd_v_r && !cmd.flush;
      s2_v_r <= s1_v_r && !cmd.flush;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r <= addr;
    s1_idx_r <= rd_idx_r;
    s2_idx_r <= s1_idx_r;
  end

  assign sts.chk_valid = s2_v_r;
  assign sts.chk_hit   = &pos;
  assign chk_idx       = s2_idx_r;

endmodule

// ===== design/tocc_ctrl.sv =====
module tocc_ctrl import tocc_pkg::*; #(
  parameter int MAX_OBSTACLES = DEF_MAX_OBSTACLES
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             in_op,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             out_is_free,
  output logic [HIT_W-1:0]                 out_hit_index,
  output logic                             out_add_rejected,
  output logic [COUNT_W-1:0]               out_stored_count,
  output cmd_t                             cmd,
  output logic [$clog2(MAX_OBSTACLES)-1:0] addr,
  input  sts_t                             sts,
  input  logic [$clog2(MAX_OBSTACLES)-1:0] chk_idx
);

  localparam int IDXW = $clog2(MAX_OBSTACLES);
  localparam int CNTW = $clog2(MAX_OBSTACLES + 1);

  typedef enum logic [7:0] {
    ST_IDLE   = 8'b0000_0001,
    ST_ADD_C  = 8'b0000_0010,
    ST_ADD_C1 = 8'b0000_0100,
    ST_ADD_O  = 8'b0000_1000,
    ST_ADD_O1 = 8'b0001_0000,
    ST_ADD_W  = 8'b0010_0000,
    ST_QRY    = 8'b0100_0000,
    ST_OUT    = 8'b1000_0000
  } state_t;

  state_t          state_r, state_nxt;
  logic [CNTW-1:0] cnt_r, cnt_nxt;
  logic [CNTW-1:0] iss_r, iss_nxt;
  logic            free_r, free_nxt;
  logic            rej_r, rej_nxt;
  logic [IDXW-1:0] hit_r, hit_nxt;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    iss_nxt   = iss_r;
    free_nxt  = free_r;
    rej_nxt   = rej_r;
    hit_nxt   = hit_r;
    cmd       = '0;
    addr      = cnt_r[IDXW-1:0];

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          hit_nxt  = '0;
          iss_nxt  = '0;
          if (in_op == OP_QUERY) begin
            free_nxt  = 1'b1;
            rej_nxt   = 1'b0;
            state_nxt = (cnt_r == '0) ? ST_OUT : ST_QRY;
          end else begin
            free_nxt = 1'b0;
            if (cnt_r >= CNTW'(MAX_OBSTACLES)) begin
              rej_nxt   = 1'b1;
              state_nxt = ST_OUT;
            end else begin
              rej_nxt   = 1'b0;
              state_nxt = ST_ADD_C;
            end
          end
        end
      end
      ST_ADD_C: begin
        cmd.src   = SRC_EDGE_C;
        state_nxt = ST_ADD_C1;
      end
      ST_ADD_C1: begin
        state_nxt = ST_ADD_O;
      end
      ST_ADD_O: begin
        cmd.src   = SRC_EDGE_O;
        cmd.cap_c = 1'b1;
        state_nxt = ST_ADD_O1;
      end
      ST_ADD_O1: begin
        state_nxt = ST_ADD_W;
      end
      ST_ADD_W: begin
        cmd.wr_en = 1'b1;
        cnt_nxt   = cnt_r + CNTW'(1);
        state_nxt = ST_OUT;
      end
      ST_QRY: begin
        if (iss_r < cnt_r) begin
          cmd.rd_en = 1'b1;
          addr      = iss_r[IDXW-1:0];
          iss_nxt   = iss_r + CNTW'(1);
        end
        // First hit wins; drop whatever is still in flight
        if (sts.chk_valid) begin
          if (sts.chk_hit) begin
            free_nxt  = 1'b0;
            hit_nxt   = chk_idx;
            cmd.flush = 1'b1;
            state_nxt = ST_OUT;
          end else if (chk_idx == IDXW'(cnt_r - CNTW'(1))) begin
            cmd.flush = 1'b1;
            state_nxt = ST_OUT;
          end
        end
      end
      ST_OUT: begin
        if (!out_stall) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      iss_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      iss_r   <= iss_nxt;
    end
  end

  always_ff @(posedge clk) begin
    free_r <= free_nxt;
    rej_r  <= rej_nxt;
    hit_r  <= hit_nxt;
  end

  assign in_stall         = (state_r != ST_IDLE);
  assign out_valid        = (state_r == ST_OUT);
  assign out_is_free      = free_r;
  assign out_add_rejected = rej_r;
  assign out_hit_index    = HIT_W'(hit_r);
  assign out_stored_count = COUNT_W'(cnt_r);

endmodule

// ===== design/triangle_obstacle_collision_check_core.sv =====
// Add: two passes through the edge evaluators, then a table write and the result word.
// Query: ends at the first hit, or after the last stored row when free; no reads when empty.
// The three-lane edge evaluator reads one stored triangle per cycle from the edge table.
// One item in flight at a time; the next word is taken the cycle after the result word.
// Reset (synchronous, rst_n low) clears the stored count and control; table rows are
// undefined until written and are never read above the count.
module triangle_obstacle_collision_check_core import tocc_pkg::*; #(
  parameter int MAX_OBSTACLES = DEF_MAX_OBSTACLES,
  parameter int COORD_WIDTH   = DEF_COORD_WIDTH
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_op,
  input  logic signed [COORD_WIDTH-1:0] in_ax,
  input  logic signed [COORD_WIDTH-1:0] in_ay,
  input  logic signed [COORD_WIDTH-1:0] in_bx,
  input  logic signed [COORD_WIDTH-1:0] in_by,
  input  logic signed [COORD_WIDTH-1:0] in_cx,
  input  logic signed [COORD_WIDTH-1:0] in_cy,
  input  logic signed [COORD_WIDTH-1:0] in_px,
  input  logic signed [COORD_WIDTH-1:0] in_py,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_is_free,
  output logic [HIT_W-1:0]              out_hit_index,
  output logic                          out_add_rejected,
  output logic [COUNT_W-1:0]            out_stored_count
);

  localparam int IDXW = $clog2(MAX_OBSTACLES);

  cmd_t            cmd;
  sts_t            sts;
  logic [IDXW-1:0] addr;
  logic [IDXW-1:0] chk_idx;

  tocc_ctrl #(
    .MAX_OBSTACLES(MAX_OBSTACLES)
  ) u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_op            (in_op),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_is_free      (out_is_free),
    .out_hit_index    (out_hit_index),
    .out_add_rejected (out_add_rejected),
    .out_stored_count (out_stored_count),
    .cmd              (cmd),
    .addr             (addr),
    .sts              (sts),
    .chk_idx          (chk_idx)
  );

  tocc_dp #(
    .MAX_OBSTACLES(MAX_OBSTACLES),
    .COORD_WIDTH  (COORD_WIDTH)
  ) u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .addr    (addr),
    .ax      (in_ax),
    .ay      (in_ay),
    .bx      (in_bx),
    .by      (in_by),
    .cx      (in_cx),
    .cy      (in_cy),
    .px      (in_px),
    .py      (in_py),
    .sts     (sts),
    .chk_idx (chk_idx)
  );

endmodule
